// ----- src/lpht_pkg.sv -----
// Shared types and codes for the linear-probe hash table.
// Request/response payload structs, status codes, controller/datapath links.
// No dependencies.
`timescale 1ns / 1ps

package lpht_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;

  // Key mod SLOTS by reciprocal multiply: product, quotient times SLOTS, remainder
  localparam int HASH_STEPS = 3;
  localparam int HASH_CNT_W = $clog2(HASH_STEPS);

  // Operation codes
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  // Result status codes
  localparam logic [2:0] ST_MISS     = 3'd0;
  localparam logic [2:0] ST_HIT      = 3'd1;
  localparam logic [2:0] ST_INSERTED = 3'd2;
  localparam logic [2:0] ST_REPLACED = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_ZEROKEY  = 3'd5;

  typedef struct packed {
    logic             operation;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] entry_value;
  } req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [VAL_W-1:0] found_value;
  } rsp_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic       clear_step;
    logic       load;
    logic       hash_step;
    logic       advance;
    logic       write_entry;
    logic       respond;
    logic [2:0] rsp_status;
    logic       take_value;
  } ctrl_t;

  // Datapath -> controller status
  typedef struct packed {
    logic zero_key;
    logic serial_hash;
    logic hash_last;
    logic is_insert;
    logic slot_empty;
    logic slot_match;
    logic last_probe;
    logic idx_last;
  } stat_t;

endpackage

// ----- src/lpht_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lpht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/lpht_datapath.sv -----
// Datapath of the hash table: request latch, slot index/probe counters,
// reciprocal modulo, key and value RAMs, response register.
// Depends on lpht_pkg and lpht_ram.
`timescale 1ns / 1ps

module lpht_datapath #(
  parameter int SLOTS = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  lpht_pkg::req_t req,
  input  lpht_pkg::ctrl_t ctrl,
  output lpht_pkg::stat_t stat,
  output lpht_pkg::rsp_t rsp,
  output logic           done
);

  localparam int  IW   = $clog2(SLOTS);
  localparam bit  POW2 = ((SLOTS & (SLOTS - 1)) == 0);
  // 2^(31+IW) / SLOTS: the quotient estimate is exact or one low
  localparam logic [lpht_pkg::KEY_W-1:0] RECIP =
    lpht_pkg::KEY_W'((64'd1 << (31 + IW)) / SLOTS);

  lpht_pkg::req_t                        req_q;
  logic [IW-1:0]                         idx;
  logic [IW-1:0]                         idx_inc;
  logic [IW-1:0]                         mod_next;
  logic [IW-1:0]                         probes;
  logic [lpht_pkg::HASH_CNT_W-1:0]       hash_cnt;
  logic [63:0]                           hash_prod;
  logic [lpht_pkg::KEY_W-1:0]            hash_quo;
  logic [lpht_pkg::KEY_W-1:0]            hash_qd;
  logic [lpht_pkg::KEY_W-1:0]            hash_rem;
  logic [lpht_pkg::KEY_W-1:0]            key_rd;
  logic [lpht_pkg::VAL_W-1:0]            val_rd;
  logic                                  key_we;
  logic [lpht_pkg::KEY_W-1:0]            key_wdata;

  // Next slot with wrap
  assign idx_inc = (idx == IW'(SLOTS - 1)) ? '0 : idx + 1'b1;

  // Key mod SLOTS: estimated quotient, back-multiply, one correcting subtract
  assign hash_quo = lpht_pkg::KEY_W'(hash_prod >> (31 + IW));
  assign hash_rem = req_q.key - hash_qd;
  assign mod_next = (hash_rem >= lpht_pkg::KEY_W'(SLOTS))
                    ? IW'(hash_rem - lpht_pkg::KEY_W'(SLOTS)) : IW'(hash_rem);

  // Slot index doubles as the clear sweep counter after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      idx  <= '0;
      done <= 1'b0;
    end else begin
      done <= ctrl.respond;
      if (ctrl.clear_step || ctrl.advance) begin
        idx <= idx_inc;
      end else if (ctrl.load) begin
        idx <= POW2 ? req.key[IW-1:0] : '0;
      end else if (ctrl.hash_step && stat.hash_last) begin
        idx <= mod_next;
      end
    end
  end

  // Request latch, hash pipeline and probe counter
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      req_q    <= req;
      hash_cnt <= '0;
      probes   <= '0;
    end else begin
      if (ctrl.hash_step) begin
        hash_prod <= 64'(req_q.key) * 64'(RECIP);
        hash_qd   <= hash_quo * lpht_pkg::KEY_W'(SLOTS);
        hash_cnt  <= hash_cnt + 1'b1;
      end
      if (ctrl.advance) begin
        probes <= probes + 1'b1;
      end
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (ctrl.respond) begin
      rsp.status      <= ctrl.rsp_status;
      rsp.found_value <= ctrl.take_value ? val_rd : '0;
    end
  end

  // Key store: zeroed by the clear sweep, written on insert
  assign key_we    = ctrl.clear_step | ctrl.write_entry;
  assign key_wdata = ctrl.clear_step ? '0 : req_q.key;

  lpht_ram #(
    .WIDTH (lpht_pkg::KEY_W),
    .DEPTH (SLOTS)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (idx),
    .wdata (key_wdata),
    .raddr (idx),
    .rdata (key_rd)
  );

  lpht_ram #(
    .WIDTH (lpht_pkg::VAL_W),
    .DEPTH (SLOTS)
  ) u_val_ram (
    .clk   (clk),
    .we    (ctrl.write_entry),
    .waddr (idx),
    .wdata (req_q.entry_value),
    .raddr (idx),
    .rdata (val_rd)
  );

  // Status back to the controller
  always_comb begin
    stat.zero_key    = (req.key == '0);
    stat.serial_hash = !POW2;
    stat.hash_last   = (hash_cnt == lpht_pkg::HASH_CNT_W'(lpht_pkg::HASH_STEPS - 1));
    stat.is_insert   = (req_q.operation == lpht_pkg::OP_INSERT);
    stat.slot_empty  = (key_rd == '0);
    stat.slot_match  = (key_rd == req_q.key);
    stat.last_probe  = (probes == IW'(SLOTS - 1));
    stat.idx_last    = (idx == IW'(SLOTS - 1));
  end

endmodule

// ----- src/lpht_ctrl.sv -----
// Controller state machine of the hash table: clear sweep, hashing,
// probe sequencing and response selection.
// Depends on lpht_pkg.
`timescale 1ns / 1ps

module lpht_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  lpht_pkg::stat_t stat,
  output lpht_pkg::ctrl_t ctrl,
  output logic            busy
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // State register; reset starts the key store sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    ctrl       = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        ctrl.clear_step = 1'b1;
        if (stat.idx_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (stat.zero_key) begin
            ctrl.respond    = 1'b1;
            ctrl.rsp_status = lpht_pkg::ST_ZEROKEY;
          end else begin
            ctrl.load  = 1'b1;
            state_next = stat.serial_hash ? S_HASH : S_READ;
          end
        end
      end
      S_HASH: begin
        ctrl.hash_step = 1'b1;
        if (stat.hash_last) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (stat.is_insert) begin
          if (stat.slot_empty || stat.slot_match) begin
            ctrl.write_entry = 1'b1;
            ctrl.respond     = 1'b1;
            ctrl.rsp_status  = stat.slot_empty ? lpht_pkg::ST_INSERTED
                                               : lpht_pkg::ST_REPLACED;
            state_next       = S_IDLE;
          end else if (stat.last_probe) begin
            ctrl.respond    = 1'b1;
            ctrl.rsp_status = lpht_pkg::ST_FULL;
            state_next      = S_IDLE;
          end else begin
            ctrl.advance = 1'b1;
            state_next   = S_READ;
          end
        end else begin
          if (stat.slot_empty) begin
            ctrl.respond    = 1'b1;
            ctrl.rsp_status = lpht_pkg::ST_MISS;
            state_next      = S_IDLE;
          end else if (stat.slot_match) begin
            ctrl.respond    = 1'b1;
            ctrl.rsp_status = lpht_pkg::ST_HIT;
            ctrl.take_value = 1'b1;
            state_next      = S_IDLE;
          end else if (stat.last_probe) begin
            ctrl.respond    = 1'b1;
            ctrl.rsp_status = lpht_pkg::ST_MISS;
            state_next      = S_IDLE;
          end else begin
            ctrl.advance = 1'b1;
            state_next   = S_READ;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

  // Every response ends the request
  a_rsp_to_idle: assert property (@(posedge clk) disable iff (rst)
    ctrl.respond |=> state == S_IDLE)
    else $error("response not followed by idle");

  // Probing never runs past the last slot
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    ctrl.advance |-> !stat.last_probe)
    else $error("probe advanced past last slot");

  // Table entries are written only in the slot check of an insert
  a_write_in_check: assert property (@(posedge clk) disable iff (rst)
    ctrl.write_entry |-> state == S_CHECK && stat.is_insert)
    else $error("entry write outside insert check");

  // Clear sweep hands over to idle at the last slot
  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR && stat.idx_last) |=> state == S_IDLE)
    else $error("clear sweep did not finish");

endmodule

// ----- src/linear_probe_hash_table.sv -----
// Top level of the linear-probe hash table.
// Depends on lpht_pkg, lpht_ctrl and lpht_datapath.
//
//   channel   handshake          payload
//   request   start & !busy      req (operation, key, entry_value)
//   result    done (1 cycle)     rsp (status, found_value)
//
// A request with a nonzero key is loaded, then for each of the P slots probed
// (1..SLOTS) the slot address is applied (S_READ) and the registered RAM read
// data checked (S_CHECK). A non power-of-two SLOTS first computes key mod SLOTS
// by reciprocal multiply (S_HASH). A zero key is answered directly from idle.
// After reset the key store is swept to zero slot by slot with busy high.
// done pulses for one cycle and cannot be held off; the next request may be
// taken in that cycle.
`timescale 1ns / 1ps

module linear_probe_hash_table #(
  parameter int SLOTS = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  lpht_pkg::req_t req,
  output logic           done,
  output lpht_pkg::rsp_t rsp
);

  lpht_pkg::ctrl_t ctrl;
  lpht_pkg::stat_t stat;

  // Sequencer
  lpht_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  // Storage and compare
  lpht_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .ctrl (ctrl),
    .stat (stat),
    .rsp  (rsp),
    .done (done)
  );

endmodule

// ----- bench/tb_linear_probe_hash_table.sv -----
// Self-checking bench for linear_probe_hash_table: directed and random lookups and inserts.
// A shadow table predicts each result; depends on lpht_pkg and the RTL under src.
`timescale 1ns / 1ps

module tb_linear_probe_hash_table;

  localparam int SLOTS = 256;
  localparam int CYCLE_LIMIT = 2_000_000;
  // Longest request: every slot probed, plus margin
  localparam int SETTLE_CYCLES = 2 * SLOTS + 64;

  typedef struct {
    lpht_pkg::req_t rq;
    bit             drain;  // hold this one back until nothing is outstanding
  } plan_item_t;

  logic           clk = 1'b0;
  logic           rst;
  logic           start;
  logic           busy;
  lpht_pkg::req_t req;
  logic           done;
  lpht_pkg::rsp_t rsp;

  plan_item_t     req_plan_q[$];
  lpht_pkg::rsp_t awaited_rsp_q[$];

  // Shadow of the block's stores, empty at start
  bit [lpht_pkg::KEY_W-1:0] shadow_key[SLOTS];
  bit [lpht_pkg::VAL_W-1:0] shadow_val[SLOTS];

  // Generator-side bookkeeping of keys that will be in the table
  bit                         planned_key[logic [lpht_pkg::KEY_W-1:0]];
  logic [lpht_pkg::KEY_W-1:0] known_q[$];

  int n_accepted;
  int n_errors;
  int n_cycles;

  linear_probe_hash_table #(
    .SLOTS(SLOTS)
  ) u_top (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  always #5 clk = ~clk;

  // Apply one request to the shadow table and return its result
  function automatic lpht_pkg::rsp_t table_access(lpht_pkg::req_t rq);
    lpht_pkg::rsp_t r;
    int unsigned    idx;
    r.status      = lpht_pkg::ST_MISS;
    r.found_value = '0;
    if (rq.key == '0) begin
      r.status = lpht_pkg::ST_ZEROKEY;
    end else begin
      idx = rq.key % SLOTS;
      if (rq.operation == lpht_pkg::OP_LOOKUP) begin
        for (int n = 0; n < SLOTS; n++) begin
          if (shadow_key[idx] == '0) break;
          if (shadow_key[idx] == rq.key) begin
            r.status      = lpht_pkg::ST_HIT;
            r.found_value = shadow_val[idx];
            break;
          end
          idx = (idx + 1 >= SLOTS) ? 0 : idx + 1;
        end
      end else begin
        r.status = lpht_pkg::ST_FULL;
        for (int n = 0; n < SLOTS; n++) begin
          if (shadow_key[idx] == '0 || shadow_key[idx] == rq.key) begin
            r.status        = (shadow_key[idx] == '0) ? lpht_pkg::ST_INSERTED
                                                      : lpht_pkg::ST_REPLACED;
            shadow_key[idx] = rq.key;
            shadow_val[idx] = rq.entry_value;
            break;
          end
          idx = (idx + 1 >= SLOTS) ? 0 : idx + 1;
        end
      end
    end
    return r;
  endfunction

  // Sender idle rate by stretch of the run
  function automatic int idle_pct();
    if (n_accepted < 250) return 17;
    if (n_accepted < 500) return 83;
    return 0;
  endfunction

  task automatic queue_req(logic op, logic [lpht_pkg::KEY_W-1:0] k,
                           logic [lpht_pkg::VAL_W-1:0] v, bit drain);
    plan_item_t it;
    it.rq.operation   = op;
    it.rq.key         = k;
    it.rq.entry_value = v;
    it.drain          = drain;
    req_plan_q.push_back(it);
    if (op == lpht_pkg::OP_INSERT && k != '0 && !planned_key.exists(k) &&
        known_q.size() < SLOTS) begin
      planned_key[k] = 1'b1;
      known_q.push_back(k);
    end
  endtask

  // New nonzero key; clustered keys home on slots 252..3 so probes wrap
  function automatic logic [lpht_pkg::KEY_W-1:0] fresh_key(bit clustered);
    logic [lpht_pkg::KEY_W-1:0] k;
    do begin
      k = $urandom();
      if (clustered) k[7:0] = 8'($urandom_range(7) + 252);
    end while (k == '0 || planned_key.exists(k));
    return k;
  endfunction

  function automatic logic [lpht_pkg::KEY_W-1:0] known_key();
    return known_q[$urandom_range(known_q.size() - 1)];
  endfunction

  // Driver: one transfer per edge with start high and busy low
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      req   <= '0;
    end else begin
      if (start && !busy) begin
        awaited_rsp_q.push_back(table_access(req));
        n_accepted++;
      end
      if (!start || !busy) begin
        if (req_plan_q.size() != 0 && $urandom_range(99) >= idle_pct() &&
            (!req_plan_q[0].drain || (awaited_rsp_q.size() == 0 && !done))) begin
          req   <= req_plan_q[0].rq;
          start <= 1'b1;
          void'(req_plan_q.pop_front());
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: each strobed result against the oldest prediction
  always @(posedge clk) begin : result_check
    lpht_pkg::rsp_t want;
    if (!rst && done) begin
      if (awaited_rsp_q.size() == 0) begin
        $display("%0t: unexpected result status=%0d found_value=%h",
                 $time, rsp.status, rsp.found_value);
        n_errors++;
      end else begin
        want = awaited_rsp_q.pop_front();
        if (rsp.status !== want.status) begin
          $display("%0t: status mismatch expected=%0d actual=%0d",
                   $time, want.status, rsp.status);
          n_errors++;
        end
        if (rsp.found_value !== want.found_value) begin
          $display("%0t: found_value mismatch expected=%h actual=%h",
                   $time, want.found_value, rsp.found_value);
          n_errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int pick;
    rst = 1'b1;

    // Directed: zero keys, empty table, wrap from the last slot, replace, probe stops
    queue_req(lpht_pkg::OP_LOOKUP, 32'h0000_0000, 32'h1234_5678, 1'b0);
    queue_req(lpht_pkg::OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    queue_req(lpht_pkg::OP_LOOKUP, 32'h0000_0005, 32'h0000_0000, 1'b0);
    queue_req(lpht_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    queue_req(lpht_pkg::OP_INSERT, 32'h0000_01FF, 32'h0000_0000, 1'b0);
    queue_req(lpht_pkg::OP_INSERT, 32'h0000_02FF, 32'hA5A5_A5A5, 1'b0);
    queue_req(lpht_pkg::OP_LOOKUP, 32'h0000_02FF, 32'h0000_0000, 1'b0);
    queue_req(lpht_pkg::OP_LOOKUP, 32'h0000_03FF, 32'hFFFF_FFFF, 1'b0);
    queue_req(lpht_pkg::OP_INSERT, 32'h0000_01FF, 32'h5A5A_5A5A, 1'b0);
    queue_req(lpht_pkg::OP_LOOKUP, 32'h0000_01FF, 32'h0000_0000, 1'b0);
    queue_req(lpht_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    queue_req(lpht_pkg::OP_INSERT, 32'h0000_0100, 32'h0F0F_0F0F, 1'b0);
    queue_req(lpht_pkg::OP_LOOKUP, 32'h0000_0100, 32'h0000_0000, 1'b0);
    queue_req(lpht_pkg::OP_INSERT, 32'h8000_0001, 32'h0000_0001, 1'b0);
    queue_req(lpht_pkg::OP_LOOKUP, 32'h8000_0001, 32'h0000_0000, 1'b0);
    queue_req(lpht_pkg::OP_LOOKUP, 32'h0000_0001, 32'h0000_0000, 1'b0);
    queue_req(lpht_pkg::OP_INSERT, 32'h7FFF_FFFE, 32'h1234_5678, 1'b0);
    queue_req(lpht_pkg::OP_LOOKUP, 32'h7FFF_FFFE, 32'h0000_0000, 1'b0);

    // Random, light load: clustered keys, hits, misses, replaces
    for (int i = 0; i < 240; i++) begin
      pick = $urandom_range(99);
      if (pick < 20)
        queue_req(lpht_pkg::OP_INSERT, fresh_key(1'b1), $urandom(), i == 0);
      else if (pick < 40)
        queue_req(lpht_pkg::OP_INSERT, known_key(), $urandom(), i == 0);
      else if (pick < 65)
        queue_req(lpht_pkg::OP_LOOKUP, known_key(), $urandom(), i == 0);
      else if (pick < 85)
        queue_req(lpht_pkg::OP_LOOKUP, fresh_key(1'b1), $urandom(), i == 0);
      else if (pick < 90)
        queue_req(1'($urandom_range(1)), '0, $urandom(), i == 0);
      else
        queue_req(1'($urandom_range(1)), fresh_key(1'b0), $urandom(), i == 0);
    end

    // Fill every slot, with lookups mixed in
    queue_req(lpht_pkg::OP_LOOKUP, known_key(), $urandom(), 1'b1);
    while (known_q.size() < SLOTS) begin
      if ($urandom_range(4) == 0)
        queue_req(lpht_pkg::OP_LOOKUP, known_key(), $urandom(), 1'b0);
      else
        queue_req(lpht_pkg::OP_INSERT, fresh_key(1'b0), $urandom(), 1'b0);
    end

    // Full table: refused insert, miss after a full sweep, replace, hit
    queue_req(lpht_pkg::OP_INSERT, fresh_key(1'b0), 32'hFFFF_FFFF, 1'b1);
    queue_req(lpht_pkg::OP_LOOKUP, fresh_key(1'b0), 32'h0000_0000, 1'b0);
    queue_req(lpht_pkg::OP_INSERT, known_key(), 32'h0000_0000, 1'b0);
    queue_req(lpht_pkg::OP_LOOKUP, known_key(), 32'h0000_0000, 1'b0);
    queue_req(lpht_pkg::OP_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b0);
    for (int i = 0; i < 260; i++) begin
      pick = $urandom_range(99);
      if (pick < 25)
        queue_req(lpht_pkg::OP_INSERT, fresh_key(1'($urandom_range(1))), $urandom(), 1'b0);
      else if (pick < 50)
        queue_req(lpht_pkg::OP_INSERT, known_key(), $urandom(), 1'b0);
      else if (pick < 75)
        queue_req(lpht_pkg::OP_LOOKUP, known_key(), $urandom(), 1'b0);
      else if (pick < 90)
        queue_req(lpht_pkg::OP_LOOKUP, fresh_key(1'($urandom_range(1))), $urandom(), 1'b0);
      else
        queue_req(1'($urandom_range(1)), '0, $urandom(), 1'b0);
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Drain: all requests taken, every result back, then a quiet window
    do @(negedge clk);
    while (req_plan_q.size() != 0 || start || awaited_rsp_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
